### sv/pcc_pkg.sv
// shared constants, types and the crc byte update for the page crc checker
`default_nettype none

package pcc_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int POS_W      = $clog2(PAGE_BYTES);
    localparam int OFFSET_W   = 12;
    localparam int CMP_W      = ((POS_W > OFFSET_W) ? POS_W : OFFSET_W) + 1;
    localparam int CFG_IDX_W  = 2;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PAGE_BYTES - 1);

    localparam logic [OFFSET_W-1:0] CHECKSUM_OFFSET_RESET = OFFSET_W'(4);
    localparam logic [OFFSET_W-1:0] MAGIC_OFFSET_RESET    = OFFSET_W'(0);
    localparam logic [31:0]         EXPECTED_MAGIC_RESET  = 32'h0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHECKSUM_OFFSET = 2'd0,
        CFG_MAGIC_OFFSET    = 2'd1,
        CFG_EXPECTED_MAGIC  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] lane;
    } lane_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = {24'h000000, crc[7:0] ^ b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c ^ (crc >> 8);
    endfunction

    function automatic logic [31:0] put_lane(input logic [31:0] word, input logic [1:0] lane,
                                             input logic [7:0] b);
        logic [31:0] w;
        w = word;
        unique case (lane)
            2'd0: w[7:0]   = b;
            2'd1: w[15:8]  = b;
            2'd2: w[23:16] = b;
            2'd3: w[31:24] = b;
            default: w = word;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### sv/pcc_lane_decode.sv
// finds which byte lane of a four-byte field the current page position falls in
`default_nettype none

module pcc_lane_decode (
    input  wire logic [pcc_pkg::POS_W-1:0]    pos,
    input  wire logic [pcc_pkg::OFFSET_W-1:0] base,
    output pcc_pkg::lane_t                    lane
);

    logic [pcc_pkg::CMP_W-1:0] diff;

    assign diff = pcc_pkg::CMP_W'(pos) - pcc_pkg::CMP_W'(base);

    always_comb
    begin
        lane.hit  = (diff[pcc_pkg::CMP_W-1:2] == '0);
        lane.lane = diff[1:0];
    end

endmodule

`default_nettype wire

### sv/page_crc32_checker.sv
// top level of the page crc checker: byte stream in, one result beat per page out
// result: the beat is registered and becomes valid in the cycle after the last page byte is taken
// throughput: one byte per cycle; only the last byte of a page waits while the
// previous page's result beat is still held by a stalled output
// reset: offsets and expected magic go to their defaults, page state is cleared
// and no result is pending; a page also clears itself after its last byte
`default_nettype none

module page_crc32_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [7:0]                        data_byte,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [31:0]                            computed_crc,
    output logic                                   crc_matches,
    output logic                                   magic_matches,
    output logic                                   page_ok,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                       cfg_data
);

    logic [pcc_pkg::OFFSET_W-1:0] checksum_offset_reg;
    logic [pcc_pkg::OFFSET_W-1:0] magic_offset_reg;
    logic [31:0]                  expected_magic_reg;

    logic [31:0]               crc_running_reg, crc_running_next;
    logic [pcc_pkg::POS_W-1:0] byte_position_reg;
    logic [31:0]               stored_crc_reg, stored_crc_next;
    logic [31:0]               stored_magic_reg, stored_magic_next;

    logic        out_valid_reg;
    logic [31:0] computed_crc_reg, computed_crc_next;
    logic        crc_matches_reg, magic_matches_reg, page_ok_reg;
    logic        cm_next, mm_next;

    pcc_pkg::lane_t crc_lane, magic_lane;
    logic           is_last, accept;
    logic [7:0]     fed;

    pcc_lane_decode u_crc_lane (
        .pos  (byte_position_reg),
        .base (checksum_offset_reg),
        .lane (crc_lane)
    );

    pcc_lane_decode u_magic_lane (
        .pos  (byte_position_reg),
        .base (magic_offset_reg),
        .lane (magic_lane)
    );

    assign is_last   = (byte_position_reg == pcc_pkg::LAST_POS);
    assign in_stall  = is_last && out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        stored_crc_next   = crc_lane.hit ?
                            pcc_pkg::put_lane(stored_crc_reg, crc_lane.lane, data_byte) :
                            stored_crc_reg;
        stored_magic_next = magic_lane.hit ?
                            pcc_pkg::put_lane(stored_magic_reg, magic_lane.lane, data_byte) :
                            stored_magic_reg;
        fed               = crc_lane.hit ? 8'h00 : data_byte;
        crc_running_next  = pcc_pkg::crc_byte(crc_running_reg, fed);
        computed_crc_next = crc_running_next ^ pcc_pkg::CRC_INIT;
        cm_next           = (stored_crc_next == computed_crc_next);
        mm_next           = (stored_magic_next == expected_magic_reg);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            checksum_offset_reg <= pcc_pkg::CHECKSUM_OFFSET_RESET;
            magic_offset_reg    <= pcc_pkg::MAGIC_OFFSET_RESET;
            expected_magic_reg  <= pcc_pkg::EXPECTED_MAGIC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pcc_pkg::CFG_CHECKSUM_OFFSET:
                    checksum_offset_reg <= cfg_data[pcc_pkg::OFFSET_W-1:0];
                pcc_pkg::CFG_MAGIC_OFFSET:
                    magic_offset_reg    <= cfg_data[pcc_pkg::OFFSET_W-1:0];
                pcc_pkg::CFG_EXPECTED_MAGIC:
                    expected_magic_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // page state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_running_reg   <= pcc_pkg::CRC_INIT;
            byte_position_reg <= '0;
            stored_crc_reg    <= '0;
            stored_magic_reg  <= '0;
        end
        else if (accept)
        begin
            if (is_last)
            begin
                crc_running_reg   <= pcc_pkg::CRC_INIT;
                byte_position_reg <= '0;
                stored_crc_reg    <= '0;
                stored_magic_reg  <= '0;
            end
            else
            begin
                crc_running_reg   <= crc_running_next;
                byte_position_reg <= byte_position_reg + 1'b1;
                stored_crc_reg    <= stored_crc_next;
                stored_magic_reg  <= stored_magic_next;
            end
        end
    end

    // result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && is_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_last)
        begin
            computed_crc_reg  <= computed_crc_next;
            crc_matches_reg   <= cm_next;
            magic_matches_reg <= mm_next;
            page_ok_reg       <= cm_next && mm_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign computed_crc  = computed_crc_reg;
    assign crc_matches   = crc_matches_reg;
    assign magic_matches = magic_matches_reg;
    assign page_ok       = page_ok_reg;

endmodule

`default_nettype wire

### dv/page_crc32_checker_test.sv
// self-checking testbench for the page crc checker: streamed pages, layout registers, verdicts
`timescale 1ns / 100ps

module page_crc32_checker_test;

    localparam int          HOLD_CYCLES = 10000;
    localparam int unsigned CYCLE_LIMIT = 8_000_000;

    typedef enum int {
        PAGE_WELL_FORMED,
        PAGE_BAD_MAGIC,
        PAGE_BAD_CRC,
        PAGE_NOISE,
        PAGE_ZEROS,
        PAGE_ONES
    } page_kind_t;

    typedef enum int {
        GAPS_NONE,
        GAPS_SPARSE,
        GAPS_DENSE
    } gap_mode_t;

    typedef struct {
        logic [7:0] value;
        int         gap;
    } byte_beat_t;

    typedef struct {
        logic [31:0] crc;
        logic        crc_ok;
        logic        magic_ok;
        logic        ok;
    } page_verdict_t;

    logic                its_clk_dummy_unused_never;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] computed_crc;
    logic        crc_matches;
    logic        magic_matches;
    logic        page_ok;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    pcc_pkg::cfg_index_t cfg_index = pcc_pkg::CFG_CHECKSUM_OFFSET;
    logic [31:0] cfg_data = 32'h0;

    page_crc32_checker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .computed_crc  (computed_crc),
        .crc_matches   (crc_matches),
        .magic_matches (magic_matches),
        .page_ok       (page_ok),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    byte_beat_t    byte_q[$];
    page_verdict_t verdict_q[$];

    // register copies
    int          cfg_chk_off   = 4;
    int          cfg_magic_off = 0;
    logic [31:0] cfg_magic     = 32'h0;

    // running page state
    logic [31:0] run_crc          = pcc_pkg::CRC_INIT;
    int          run_pos          = 0;
    logic [31:0] run_stored_crc   = 32'h0;
    logic [31:0] run_stored_magic = 32'h0;

    int unsigned mismatches  = 0;
    int unsigned pages_seen  = 0;
    int unsigned pages_good  = 0;
    int unsigned bytes_taken = 0;
    int unsigned layouts     = 1;
    int unsigned cycles      = 0;
    int          hold_ticket = 0;
    int          hold_served = 0;
    int          hold_left   = 0;
    int          rx_wait     = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ pcc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic int lane_in_field(input int pos, input int base);
        if (pos >= base && pos - base < 4)
            return pos - base;
        return -1;
    endfunction

    function automatic int draw_gap(input gap_mode_t mode);
        case (mode)
            GAPS_DENSE:  return $urandom_range(0, 13);
            GAPS_SPARSE: return ($urandom_range(0, 31) == 0) ? $urandom_range(1, 13) : 0;
            default:     return 0;
        endcase
    endfunction

    function automatic int draw_offset();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return 4092;
        if (r == 2)
            return $urandom_range(4093, 4095);
        return $urandom_range(0, 4092);
    endfunction

    function automatic logic [31:0] draw_magic();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return 32'h0;
        if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // one page byte through the expected-verdict model
    task automatic page_absorb(input logic [7:0] b);
        int            cl;
        int            ml;
        logic [7:0]    fed;
        page_verdict_t v;
        cl  = lane_in_field(run_pos, cfg_chk_off);
        ml  = lane_in_field(run_pos, cfg_magic_off);
        fed = b;
        if (cl >= 0)
        begin
            run_stored_crc[cl*8 +: 8] = b;
            fed = 8'h00;
        end
        if (ml >= 0)
            run_stored_magic[ml*8 +: 8] = b;
        run_crc = crc32_step(run_crc, fed);
        if (run_pos + 1 < pcc_pkg::PAGE_BYTES)
            run_pos++;
        else
        begin
            v.crc      = ~run_crc;
            v.crc_ok   = (run_stored_crc == v.crc);
            v.magic_ok = (run_stored_magic == cfg_magic);
            v.ok       = v.crc_ok && v.magic_ok;
            verdict_q.push_back(v);
            run_crc          = pcc_pkg::CRC_INIT;
            run_pos          = 0;
            run_stored_crc   = 32'h0;
            run_stored_magic = 32'h0;
        end
    endtask

    task automatic write_reg(input pcc_pkg::cfg_index_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            pcc_pkg::CFG_CHECKSUM_OFFSET:
                cfg_chk_off   = int'(value[pcc_pkg::OFFSET_W-1:0]);
            pcc_pkg::CFG_MAGIC_OFFSET:
                cfg_magic_off = int'(value[pcc_pkg::OFFSET_W-1:0]);
            pcc_pkg::CFG_EXPECTED_MAGIC:
                cfg_magic     = value;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_layout(input int chk_off, input int magic_off, input logic [31:0] magic);
        wait_drained();
        write_reg(pcc_pkg::CFG_CHECKSUM_OFFSET, 32'(chk_off));
        write_reg(pcc_pkg::CFG_MAGIC_OFFSET, 32'(magic_off));
        write_reg(pcc_pkg::CFG_EXPECTED_MAGIC, magic);
        @(negedge clk);
        layouts++;
    endtask

    task automatic queue_page(input page_kind_t kind, input gap_mode_t mode);
        logic [7:0]  page_buf [pcc_pkg::PAGE_BYTES];
        logic [31:0] magic;
        logic [31:0] crc;
        logic [7:0]  fill;
        logic        flat;
        int          cl;
        int          flip_idx;
        int          flip_bit;
        byte_beat_t  beat;
        flat = ($urandom_range(0, 7) == 0);
        fill = 8'($urandom);
        for (int i = 0; i < pcc_pkg::PAGE_BYTES; i++)
        begin
            case (kind)
                PAGE_ZEROS: page_buf[i] = 8'h00;
                PAGE_ONES:  page_buf[i] = 8'hFF;
                default:    page_buf[i] = flat ? fill : 8'($urandom);
            endcase
        end
        if (kind == PAGE_WELL_FORMED || kind == PAGE_BAD_MAGIC || kind == PAGE_BAD_CRC)
        begin
            magic = cfg_magic;
            if (kind == PAGE_BAD_MAGIC)
            begin
                flip_bit        = $urandom_range(0, 31);
                magic[flip_bit] = ~magic[flip_bit];
            end
            for (int k = 0; k < 4; k++)
            begin
                if (cfg_magic_off + k < pcc_pkg::PAGE_BYTES)
                    page_buf[cfg_magic_off + k] = magic[k*8 +: 8];
            end
            crc = pcc_pkg::CRC_INIT;
            for (int i = 0; i < pcc_pkg::PAGE_BYTES; i++)
            begin
                cl  = lane_in_field(i, cfg_chk_off);
                crc = crc32_step(crc, (cl >= 0) ? 8'h00 : page_buf[i]);
            end
            crc = ~crc;
            for (int k = 0; k < 4; k++)
            begin
                if (cfg_chk_off + k < pcc_pkg::PAGE_BYTES)
                    page_buf[cfg_chk_off + k] = crc[k*8 +: 8];
            end
            if (kind == PAGE_BAD_CRC)
            begin
                flip_idx = $urandom_range(0, pcc_pkg::PAGE_BYTES - 1);
                flip_bit = $urandom_range(0, 7);
                page_buf[flip_idx][flip_bit] = ~page_buf[flip_idx][flip_bit];
            end
        end
        for (int i = 0; i < pcc_pkg::PAGE_BYTES; i++)
        begin
            beat.value = page_buf[i];
            beat.gap   = draw_gap(mode);
            byte_q.push_back(beat);
        end
    endtask

    function automatic page_kind_t draw_kind();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return PAGE_WELL_FORMED;
        if (r == 7)
            return PAGE_BAD_MAGIC;
        if (r == 8)
            return PAGE_BAD_CRC;
        return PAGE_NOISE;
    endfunction

    function automatic gap_mode_t draw_mode();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return GAPS_NONE;
        if (r < 9)
            return GAPS_SPARSE;
        return GAPS_DENSE;
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                page_absorb(data_byte);
                bytes_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (byte_q.size() == 0)
                    in_valid <= 1'b0;
                else if (byte_q[0].gap > 0)
                begin
                    byte_q[0].gap = byte_q[0].gap - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    data_byte <= byte_q[0].value;
                    void'(byte_q.pop_front());
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // receiver stall, counted only while a beat is waiting, plus the long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                rx_wait = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 13);
            else if (out_valid && rx_wait > 0)
                rx_wait--;
            if (hold_ticket != hold_served)
            begin
                hold_served = hold_ticket;
                hold_left   = HOLD_CYCLES;
            end
            else if (hold_left > 0)
                hold_left--;
            out_stall <= (rx_wait > 0) || (hold_left > 0);
        end
    end

    // verdict checker
    always @(posedge clk)
    begin
        page_verdict_t v;
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result beat with no page pending");
                mismatches++;
            end
            else
            begin
                v = verdict_q.pop_front();
                pages_seen++;
                if (page_ok === 1'b1)
                    pages_good++;
                if (computed_crc !== v.crc)
                begin
                    $error("computed_crc: expected %h, got %h", v.crc, computed_crc);
                    mismatches++;
                end
                if (crc_matches !== v.crc_ok)
                begin
                    $error("crc_matches: expected %b, got %b", v.crc_ok, crc_matches);
                    mismatches++;
                end
                if (magic_matches !== v.magic_ok)
                begin
                    $error("magic_matches: expected %b, got %b", v.magic_ok, magic_matches);
                    mismatches++;
                end
                if (page_ok !== v.ok)
                begin
                    $error("page_ok: expected %b, got %b", v.ok, page_ok);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int chk_off;
        int magic_off;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset layout: all-zero, all-ones and a clean page
        queue_page(PAGE_ZEROS, GAPS_SPARSE);
        queue_page(PAGE_ONES, GAPS_NONE);
        queue_page(PAGE_WELL_FORMED, GAPS_SPARSE);

        // fields at both ends of the page
        set_layout(0, 4092, 32'hFFFF_FFFF);
        queue_page(PAGE_WELL_FORMED, GAPS_NONE);
        queue_page(PAGE_BAD_CRC, GAPS_SPARSE);
        set_layout(4092, 0, $urandom);
        queue_page(PAGE_WELL_FORMED, GAPS_DENSE);
        queue_page(PAGE_BAD_MAGIC, GAPS_NONE);

        // overlapping fields
        set_layout(10, 12, $urandom);
        queue_page(PAGE_WELL_FORMED, GAPS_SPARSE);
        set_layout(20, 20, $urandom);
        queue_page(PAGE_WELL_FORMED, GAPS_NONE);

        // fields running past the last byte
        set_layout(4095, 4093, $urandom);
        queue_page(PAGE_WELL_FORMED, GAPS_SPARSE);
        queue_page(PAGE_NOISE, GAPS_NONE);

        // receiver holds off for more than two pages while bytes keep coming
        set_layout(draw_offset(), draw_offset(), draw_magic());
        hold_ticket++;
        repeat (3) queue_page(PAGE_WELL_FORMED, GAPS_NONE);

        for (int p = 0; p < 7; p++)
        begin
            chk_off   = draw_offset();
            magic_off = draw_offset();
            if ($urandom_range(0, 3) == 0)
            begin
                magic_off = chk_off + $urandom_range(0, 6) - 3;
                if (magic_off < 0)
                    magic_off = 0;
                if (magic_off > 4095)
                    magic_off = 4095;
            end
            set_layout(chk_off, magic_off, draw_magic());
            repeat (3) queue_page(draw_kind(), draw_mode());
        end

        wait_drained();
        repeat (16) @(negedge clk);
        $display("%0d pages (%0d bytes) checked over %0d register layouts, %0d passed as valid",
                 pages_seen, bytes_taken, layouts, pages_good);
        $display("covered: flat and random pages, bad crc, bad magic, overlapping and clipped fields");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
sv/pcc_pkg.sv
sv/pcc_lane_decode.sv
sv/page_crc32_checker.sv
dv/page_crc32_checker_test.sv
